/* rtl/led_strip_frame_buffer_top_macros.svh */
// Assertion macros shared by the frame buffer RTL.
`ifndef LED_STRIP_FRAME_BUFFER_TOP_MACROS_SVH
`define LED_STRIP_FRAME_BUFFER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LSFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`define LSFB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define LSFB_ASSERT(label, prop, msg)
`define LSFB_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* rtl/lsfb_pkg.sv */
// Shared constants, types and color helpers of the LED strip frame buffer.
`default_nettype none
package lsfb_pkg;

  localparam int MAX_PIXELS  = 32;
  localparam int ADDR_W      = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W       = 6;
  localparam int CH_W        = 7;
  localparam int ENTRY_W     = 3 * CH_W;
  localparam int DATA_W      = 24;
  localparam int LATCH_GROUP = 32;
  localparam int LATCH_SHIFT = $clog2(LATCH_GROUP);
  localparam int LATCH_MAX   = (MAX_PIXELS + LATCH_GROUP - 1) / LATCH_GROUP;
  localparam int LATCH_W     = $clog2(LATCH_MAX + 1);
  localparam int SUM_W       = CNT_W + 1;

  localparam logic [CNT_W-1:0] RESET_COUNT = 6'd32;
  localparam logic [7:0]       TOP_BIT     = 8'h80;

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_UPDATE = 2'd2,
    FUNC_MARK   = 2'd3
  } func_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_LATCH = 1'b1
  } kind_e;

  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic entry_t pack_color(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    pack_color = {g[7:1], r[7:1], b[7:1]};
  endfunction

  function automatic logic [DATA_W-1:0] wire_bytes(input entry_t e);
    wire_bytes = {TOP_BIT | {1'b0, e[3*CH_W-1:2*CH_W]},
                  TOP_BIT | {1'b0, e[2*CH_W-1:CH_W]},
                  TOP_BIT | {1'b0, e[CH_W-1:0]}};
  endfunction

endpackage
`default_nettype wire

/* rtl/lsfb_ifs.sv */
// Handshake channel interfaces for command, strip word and configuration traffic.
`default_nettype none
interface lsfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, func, pixel_index, red, green, blue, input ready);
  modport sink (input valid, func, pixel_index, red, green, blue, output ready);
endinterface

interface lsfb_word_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [23:0] pixel_data;
  logic        last;
  modport source (output valid, item_kind, pixel_data, last, input ready);
  modport sink (input valid, item_kind, pixel_data, last, output ready);
endinterface

interface lsfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* rtl/lsfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/led_strip_frame_buffer_top.sv */
// Top level of the LED strip frame buffer: command decode, store walk and word output.
// Set pixel, mark dirty and a clean update need no walk. A clear writes one
// pixel per cycle through the store's single write port, for each of the n pixels
// in use. A dirty update reads one pixel per cycle, while the output is not stalled,
// through the store's single read port and sends n pixel words followed by ceil(n/32)
// latch words. No command is taken while a clear or update walk runs. Per-entry valid
// bits are cleared at reset, so the store needs no clearing pass and unwritten pixels
// go out as 0x80 bytes.
`default_nettype none
`include "led_strip_frame_buffer_top_macros.svh"
module led_strip_frame_buffer_top (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  lsfb_cmd_if.sink   in_i,
  lsfb_word_if.source out_o,
  lsfb_cfg_if.sink   cfg_i
);
  import lsfb_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_LATCH  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q;
  logic [CNT_W-1:0]      n_in_use;
  logic [CNT_W-1:0]      addr_q, addr_d;
  logic [LATCH_W-1:0]    latch_q, latch_d;
  logic [LATCH_W-1:0]    latch_total;
  logic [SUM_W-1:0]      latch_sum;
  logic                  dirty_q, dirty_d;
  logic [MAX_PIXELS-1:0] valid_q, valid_d;
  logic                  pend_q, pend_d;
  logic                  vld_rd_q;
  entry_t                clr_color_q;

  logic                  out_valid_q, out_valid_d;
  logic                  out_kind_q;
  logic [DATA_W-1:0]     out_data_q;
  logic                  out_last_q;

  logic                  accept;
  logic                  idx_ok;
  logic                  slot_free;
  logic                  issue;
  logic                  load_pix;
  logic                  load_latch;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  entry_t                ram_wdata;
  entry_t                ram_rdata;
  entry_t                rd_entry;

  always_comb begin
    if (count_q == '0) begin
      n_in_use = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_PIXELS)) begin
      n_in_use = CNT_W'(MAX_PIXELS);
    end else begin
      n_in_use = count_q;
    end
  end

  assign latch_sum   = SUM_W'(n_in_use) + SUM_W'(LATCH_GROUP - 1);
  assign latch_total = LATCH_W'(latch_sum >> LATCH_SHIFT);

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign idx_ok      = (in_i.pixel_index < n_in_use);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign issue      = (state_q == ST_UPDATE) && (addr_q < n_in_use) && (!pend_q || slot_free);
  assign load_pix   = (state_q == ST_UPDATE) && pend_q && slot_free;
  assign load_latch = (state_q == ST_LATCH) && slot_free;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q[ADDR_W-1:0];
    ram_wdata = clr_color_q;
    if (state_q == ST_CLEAR) begin
      ram_we = 1'b1;
    end else if (accept && (in_i.func == FUNC_SET) && idx_ok) begin
      ram_we    = 1'b1;
      ram_waddr = in_i.pixel_index[ADDR_W-1:0];
      ram_wdata = pack_color(in_i.red, in_i.green, in_i.blue);
    end
  end

  lsfb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_PIXELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (issue),
    .raddr_i(addr_q[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = vld_rd_q ? ram_rdata : '0;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    latch_d     = latch_q;
    dirty_d     = dirty_q;
    valid_d     = valid_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
    if (issue) begin
      pend_d = 1'b1;
      addr_d = addr_q + CNT_W'(1);
    end else if (load_pix) begin
      pend_d = 1'b0;
    end
    if (load_pix || load_latch) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_i.func)
            FUNC_SET: begin
              if (idx_ok) begin
                dirty_d = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              dirty_d = 1'b1;
              addr_d  = '0;
              state_d = ST_CLEAR;
            end
            FUNC_UPDATE: begin
              if (dirty_q) begin
                dirty_d = 1'b0;
                addr_d  = '0;
                state_d = ST_UPDATE;
              end
            end
            FUNC_MARK: begin
              dirty_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        addr_d = addr_q + CNT_W'(1);
        if (addr_q == n_in_use - CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if ((addr_q == n_in_use) && (!pend_q || load_pix)) begin
          latch_d = latch_total;
          state_d = ST_LATCH;
        end
      end
      ST_LATCH: begin
        if (load_latch) begin
          latch_d = latch_q - LATCH_W'(1);
          if (latch_q == LATCH_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= RESET_COUNT;
      addr_q      <= '0;
      latch_q     <= '0;
      dirty_q     <= 1'b1;
      valid_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      latch_q     <= latch_d;
      dirty_q     <= dirty_d;
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        count_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      vld_rd_q <= valid_q[addr_q[ADDR_W-1:0]];
    end
    if (accept && (in_i.func == FUNC_CLEAR)) begin
      clr_color_q <= pack_color(in_i.red, in_i.green, in_i.blue);
    end
    if (load_pix) begin
      out_kind_q <= KIND_PIXEL;
      out_data_q <= wire_bytes(rd_entry);
      out_last_q <= 1'b0;
    end else if (load_latch) begin
      out_kind_q <= KIND_LATCH;
      out_data_q <= '0;
      out_last_q <= (latch_q == LATCH_W'(1));
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.item_kind  = out_kind_q;
  assign out_o.pixel_data = out_data_q;
  assign out_o.last       = out_last_q;

  `LSFB_ASSERT(a_no_rw_overlap, !(ram_we && issue), "store read and write overlap")
  `LSFB_ASSERT_NEXT(a_pend_held, pend_q && !slot_free, pend_q, "pending pixel read was lost")
  `LSFB_ASSERT(a_last_is_latch, !(out_o.valid && out_o.last) || out_o.item_kind,
               "last word is not a latch word")

endmodule
`default_nettype wire

/* bench/tb_led_strip_frame_buffer_top.sv */
// Self-checking testbench of the LED strip frame buffer: directed and random commands.
`timescale 1ns / 1ps
module tb_led_strip_frame_buffer_top;
  import lsfb_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct {
    kind_e       kind;
    logic [23:0] data;
    logic        last;
  } strip_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lsfb_cmd_if  cmd_if();
  lsfb_word_if word_if();
  lsfb_cfg_if  cfg_if();

  led_strip_frame_buffer_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (word_if),
    .cfg_i (cfg_if)
  );

  logic [20:0] pixel_model [MAX_PIXELS];
  logic        dirty_model;
  logic [5:0]  count_model;
  strip_word_t expected_words[$];

  int error_count = 0;
  int cmds_sent = 0;
  int words_checked = 0;
  int count_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  function automatic int pixels_used();
    if (count_model == 6'd0) begin
      return 1;
    end
    if (int'(count_model) > MAX_PIXELS) begin
      return MAX_PIXELS;
    end
    return int'(count_model);
  endfunction

  function automatic void predict_cmd(input func_e f, input logic [5:0] idx,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    int n;
    int latches;
    logic [20:0] color;
    strip_word_t w;
    n = pixels_used();
    color = {g[7:1], r[7:1], b[7:1]};
    case (f)
      FUNC_SET: begin
        if (int'(idx) < n) begin
          pixel_model[idx[ADDR_W-1:0]] = color;
          dirty_model = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < n; i++) begin
          pixel_model[ADDR_W'(i)] = color;
        end
        dirty_model = 1'b1;
      end
      FUNC_MARK: begin
        dirty_model = 1'b1;
      end
      default: begin
        if (dirty_model) begin
          for (int i = 0; i < n; i++) begin
            w.kind = KIND_PIXEL;
            w.data = {1'b1, pixel_model[ADDR_W'(i)][20:14], 1'b1,
                      pixel_model[ADDR_W'(i)][13:7], 1'b1, pixel_model[ADDR_W'(i)][6:0]};
            w.last = 1'b0;
            expected_words.push_back(w);
          end
          latches = (n + LATCH_GROUP - 1) / LATCH_GROUP;
          for (int i = 0; i < latches; i++) begin
            w.kind = KIND_LATCH;
            w.data = 24'd0;
            w.last = (i == latches - 1);
            expected_words.push_back(w);
          end
          dirty_model = 1'b0;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    error_count++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  always @(posedge clk_i) begin
    strip_word_t w;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", word_if.pixel_data, 24'd0);
      end else begin
        w = expected_words.pop_front();
        words_checked++;
        if (word_if.item_kind !== w.kind) begin
          report_mismatch("item_kind", 24'(word_if.item_kind), 24'(w.kind));
        end
        if (word_if.pixel_data !== w.data) begin
          report_mismatch("pixel_data", word_if.pixel_data, w.data);
        end
        if (word_if.last !== w.last) begin
          report_mismatch("last", 24'(word_if.last), 24'(w.last));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      word_if.ready <= 1'b0;
    end else begin
      word_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (word_if.valid && word_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d words still expected", expected_words.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_cmd(input func_e f, input logic [5:0] idx, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.func        <= f;
    cmd_if.pixel_index <= idx;
    cmd_if.red         <= r;
    cmd_if.green       <= g;
    cmd_if.blue        <= b;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_cmd(f, idx, r, g, b);
    cmds_sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [5:0] value);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    count_model = value;
    count_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_refresh();
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_UPDATE, 6'd0, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_set_pixel();
    send_cmd(FUNC_SET, 6'd0, 8'hFF, 8'h00, 8'h01);
    send_cmd(FUNC_SET, 6'd31, 8'h00, 8'hFF, 8'hFE);
    send_cmd(FUNC_SET, 6'd32, 8'h55, 8'h55, 8'h55);
    send_cmd(FUNC_SET, 6'd63, 8'hAA, 8'hAA, 8'hAA);
    send_cmd(FUNC_SET, 6'd15, 8'h80, 8'h7F, 8'hFF);
    send_cmd(FUNC_UPDATE, 6'd63, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_clear_and_mark();
    send_cmd(FUNC_CLEAR, 6'd0, 8'hFF, 8'h00, 8'hAA);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_MARK, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_pixel_count();
    write_count(6'd1);
    send_cmd(FUNC_SET, 6'd0, 8'h12, 8'h34, 8'h56);
    send_cmd(FUNC_SET, 6'd1, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(FUNC_CLEAR, 6'd0, 8'h01, 8'h02, 8'h03);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    write_count(6'd0);
    send_cmd(FUNC_SET, 6'd0, 8'hFE, 8'hFD, 8'hFC);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    write_count(6'd63);
    send_cmd(FUNC_SET, 6'd31, 8'h9C, 8'h3E, 8'hC7);
    send_cmd(FUNC_SET, 6'd40, 8'h11, 8'h22, 8'h33);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [5:0] count, input int items);
    int sel;
    int n;
    logic [5:0] idx;
    write_count(count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < items; k++) begin
      sel = $urandom_range(99);
      n = pixels_used();
      if ($urandom_range(4) == 0) begin
        idx = 6'($urandom_range(63));
      end else begin
        idx = 6'($urandom_range(n - 1));
      end
      if (sel < 55) begin
        send_cmd(FUNC_SET, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
      end else if (sel < 65) begin
        send_cmd(FUNC_CLEAR, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
      end else if (sel < 75) begin
        send_cmd(FUNC_MARK, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
      end else begin
        send_cmd(FUNC_UPDATE, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
      end
    end
    drain();
  endtask

  task automatic test_output_backpressure();
    write_count(6'($urandom_range(63)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = HOLD_CYCLES;
    for (int k = 0; k < 4; k++) begin
      send_cmd(FUNC_MARK, 6'd0, 8'h00, 8'h00, 8'h00);
      send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
    end
    drain();
    send_cmd(FUNC_SET, 6'd0, 8'hC3, 8'h3C, 8'h5A);
    send_cmd(FUNC_UPDATE, 6'd0, 8'h00, 8'h00, 8'h00);
  endtask

  initial begin
    cmd_if.valid       = 1'b0;
    cmd_if.func        = FUNC_SET;
    cmd_if.pixel_index = 6'd0;
    cmd_if.red         = 8'd0;
    cmd_if.green       = 8'd0;
    cmd_if.blue        = 8'd0;
    word_if.ready      = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.data        = 6'd0;
    for (int i = 0; i < MAX_PIXELS; i++) begin
      pixel_model[ADDR_W'(i)] = '0;
    end
    dirty_model = 1'b1;
    count_model = RESET_COUNT;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_refresh();
    test_set_pixel();
    test_clear_and_mark();
    test_pixel_count();
    test_random_phase(0, 0, 6'd32, 100);
    test_random_phase(50, 0, 6'd1, 100);
    test_random_phase(0, 50, 6'd63, 100);
    test_random_phase(8, 8, 6'($urandom_range(2, 31)), 100);
    test_output_backpressure();
    drain();

    $display("Sent %0d commands, checked %0d strip words, wrote the pixel count %0d times.",
             cmds_sent, words_checked, count_writes);
    $display("Covered idle-free, sender-idle, receiver-stall, mixed and long hold-off runs.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lsfb_pkg.sv
rtl/lsfb_ifs.sv
rtl/lsfb_ram.sv
rtl/led_strip_frame_buffer_top.sv
bench/tb_led_strip_frame_buffer_top.sv
